[rtl/keyframe_vec3_track_sampler_macros.svh]
// Assertion macros used by the checker file of the keyframe track sampler.
`ifndef KEYFRAME_VEC3_TRACK_SAMPLER_MACROS_SVH
`define KEYFRAME_VEC3_TRACK_SAMPLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KVTS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyframe sampler check failed");

// Next-cycle implication, disabled while reset is asserted.
`define KVTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyframe sampler check failed");

`endif

[rtl/kvts_pkg.sv]
// Shared types and constants of the keyframe track sampler.
package kvts_pkg;

    localparam int MAX_KEYS = 64;
    localparam int IDX_W    = $clog2(MAX_KEYS);
    localparam int CNT_W    = $clog2(MAX_KEYS + 1);
    localparam int TIME_W   = 24;
    localparam int VAL_W    = 32;
    localparam int LANES    = 3;
    localparam int FRAC_W   = 16;
    localparam int F_W      = FRAC_W + 1;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        ST_INTERP = 2'd0,
        ST_HOLD   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_EQUAL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_PREP,
        S_DIVIDE,
        S_MUL1,
        S_MUL2,
        S_LOAD
    } state_t;

    typedef struct packed {
        logic ld_diff;
        logic ld_prod;
    } lane_ctl_t;

endpackage

[rtl/kvts_div.sv]
// Restoring bit-serial divider that forms the Q0.16 interpolation factor.
module kvts_div
    import kvts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TIME_W-1:0] an,
    input  logic [TIME_W-1:0] ad,
    output logic              done,
    output logic [FRAC_W-1:0] quot
);

    logic [TIME_W-1:0] rem_reg;
    logic [TIME_W-1:0] ad_reg;
    logic [FRAC_W-1:0] q_reg;
    logic [4:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [TIME_W:0]   rem2;
    logic [TIME_W:0]   diff;
    logic              ge;

    assign rem2 = {rem_reg, 1'b0};
    assign ge   = rem2 >= {1'b0, ad_reg};
    assign diff = rem2 - {1'b0, ad_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(FRAC_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The numerator is below the divisor, so every partial remainder fits.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= an;
            ad_reg  <= ad;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[TIME_W-1:0] : rem2[TIME_W-1:0];
            q_reg   <= {q_reg[FRAC_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

[rtl/kvts_lane.sv]
// One component lane: difference, scaled product, and floor-shifted sum.
module kvts_lane
    import kvts_pkg::*;
(
    input  logic             clk,
    input  lane_ctl_t        ctl,
    input  logic [VAL_W-1:0] a,
    input  logic [VAL_W-1:0] b,
    input  logic [F_W-1:0]   f,
    output logic [VAL_W-1:0] res
);

    logic signed [VAL_W:0]       d_reg;
    logic [VAL_W-1:0]            a_reg;
    logic [VAL_W-1:0]            a2_reg;
    logic signed [VAL_W+F_W:0]   p_reg;
    logic [F_W-1:0]              f_reg;
    logic signed [VAL_W+F_W+1:0] prod;

    assign prod = d_reg * $signed({1'b0, f_reg});

    always_ff @(posedge clk)
    begin
        if (ctl.ld_diff)
        begin
            d_reg <= $signed({b[VAL_W-1], b}) - $signed({a[VAL_W-1], a});
            a_reg <= a;
            f_reg <= f;
        end
        if (ctl.ld_prod)
        begin
            p_reg  <= prod[VAL_W+F_W:0];
            a2_reg <= a_reg;
        end
    end

    // Arithmetic shift of the product by 16 is a floor toward minus infinity.
    assign res = a2_reg + p_reg[VAL_W+FRAC_W-1:FRAC_W];

endmodule

[rtl/keyframe_vec3_track_sampler.sv]
// A key write is stored as it is accepted and leaves the block ready. For a sample of a
// nonempty track, key times are scanned one slot per cycle through the single read port of
// the key memory up to the interval start found; unless the factor is 0 or 1, a 16-step serial
// divider forms it. Three parallel lanes interpolate x, y, z in two multiply stages. One item
// is worked on at a time; a finished result waits in the output register while the next
// item is accepted. The key memory has no reset; slots must be written before they are sampled.
module keyframe_vec3_track_sampler
    import kvts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              operation,
    input  logic [5:0]        key_index,
    input  logic [TIME_W-1:0] key_time,
    input  logic [VAL_W-1:0]  key_x,
    input  logic [VAL_W-1:0]  key_y,
    input  logic [VAL_W-1:0]  key_z,
    input  logic [TIME_W-1:0] sample_time,
    input  logic              cfg_we,
    input  logic [6:0]        cfg_wdata,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [VAL_W-1:0]  out_x,
    output logic [VAL_W-1:0]  out_y,
    output logic [VAL_W-1:0]  out_z,
    output logic [1:0]        status
);

    localparam int VEC_W = LANES * VAL_W;

    logic [TIME_W-1:0] times_mem [MAX_KEYS];
    logic [VEC_W-1:0]  vals_mem  [MAX_KEYS];

    state_t            state_reg, state_next;
    logic [6:0]        kc_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [TIME_W-1:0] t_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [TIME_W-1:0] time_rd_reg;
    logic [VEC_W-1:0]  vals_rd_reg;
    logic [TIME_W-1:0] prev_time_reg;
    logic [VEC_W-1:0]  prev_vals_reg;
    logic [VEC_W-1:0]  a_reg;
    logic [VEC_W-1:0]  b_reg;
    logic [F_W-1:0]    f_reg;
    status_t           status_reg;
    logic signed [TIME_W:0] num_reg;
    logic signed [TIME_W:0] den_reg;
    logic              out_valid_reg;
    logic [VAL_W-1:0]  out_x_reg, out_y_reg, out_z_reg;
    logic [1:0]        status_out_reg;

    logic              accept, wr_key, smp;
    logic              rd_en;
    logic [IDX_W-1:0]  raddr;
    logic [CNT_W-1:0]  n_sat;
    logic              hit, last;
    logic [TIME_W-1:0] an, ad;
    logic              f_zero, f_one, need_div;
    logic              div_start, div_done;
    logic [FRAC_W-1:0] div_q;
    logic              do_load;
    lane_ctl_t         lane_ctl;
    logic [VAL_W-1:0]  lane_res [LANES];

    assign accept = in_valid && in_ready;
    assign wr_key = accept && (operation == OP_WRITE);
    assign smp    = accept && (operation == OP_SAMPLE);
    assign n_sat  = (kc_reg > 7'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : CNT_W'(kc_reg);

    assign hit  = (rd_idx_reg != '0) && (t_reg < time_rd_reg);
    assign last = ({1'b0, rd_idx_reg} == (n_reg - CNT_W'(1)));

    assign an       = num_reg[TIME_W] ? TIME_W'(-num_reg) : num_reg[TIME_W-1:0];
    assign ad       = den_reg[TIME_W] ? TIME_W'(-den_reg) : den_reg[TIME_W-1:0];
    assign f_zero   = (num_reg == '0) || (num_reg[TIME_W] != den_reg[TIME_W]);
    assign f_one    = an >= ad;
    assign need_div = (den_reg != '0) && !f_zero && !f_one;
    assign do_load  = !out_valid_reg || out_ready;

    // Key memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_key)
        begin
            times_mem[key_index[IDX_W-1:0]] <= key_time;
            vals_mem[key_index[IDX_W-1:0]]  <= {key_z, key_y, key_x};
        end
        if (rd_en)
        begin
            time_rd_reg <= times_mem[raddr];
            vals_rd_reg <= vals_mem[raddr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (smp)
                    state_next = (n_sat == '0) ? S_MUL1 : S_SEARCH;
            end
            S_SEARCH:
            begin
                if (hit)
                    state_next = S_PREP;
                else if (last)
                    state_next = S_MUL1;
            end
            S_PREP:   state_next = need_div ? S_DIVIDE : S_MUL1;
            S_DIVIDE:
            begin
                if (div_done)
                    state_next = S_MUL1;
            end
            S_MUL1:   state_next = S_MUL2;
            S_MUL2:   state_next = S_LOAD;
            S_LOAD:
            begin
                if (do_load)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready         = 1'b0;
        rd_en            = 1'b0;
        raddr            = '0;
        div_start        = 1'b0;
        lane_ctl.ld_diff = 1'b0;
        lane_ctl.ld_prod = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                rd_en    = smp;
            end
            S_SEARCH:
            begin
                rd_en = 1'b1;
                raddr = rd_idx_reg + IDX_W'(1);
            end
            S_PREP:   div_start        = need_div;
            S_MUL1:   lane_ctl.ld_diff = 1'b1;
            S_MUL2:   lane_ctl.ld_prod = 1'b1;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                kc_reg <= cfg_wdata;
            if (state_reg == S_LOAD && do_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (smp)
                begin
                    t_reg      <= sample_time;
                    n_reg      <= n_sat;
                    rd_idx_reg <= '0;
                    a_reg      <= '0;
                    b_reg      <= '0;
                    f_reg      <= '0;
                    status_reg <= ST_EMPTY;
                end
            end
            S_SEARCH:
            begin
                if (hit)
                begin
                    num_reg <= $signed({1'b0, t_reg}) - $signed({1'b0, prev_time_reg});
                    den_reg <= $signed({1'b0, time_rd_reg}) - $signed({1'b0, prev_time_reg});
                    a_reg   <= prev_vals_reg;
                    b_reg   <= vals_rd_reg;
                end
                else if (last)
                begin
                    // Past the last interval, or a single key: hold the key just read.
                    a_reg      <= vals_rd_reg;
                    b_reg      <= vals_rd_reg;
                    f_reg      <= '0;
                    status_reg <= ST_HOLD;
                end
                else
                begin
                    prev_time_reg <= time_rd_reg;
                    prev_vals_reg <= vals_rd_reg;
                    rd_idx_reg    <= rd_idx_reg + IDX_W'(1);
                end
            end
            S_PREP:
            begin
                if (den_reg == '0)
                begin
                    b_reg      <= a_reg;
                    f_reg      <= '0;
                    status_reg <= ST_EQUAL;
                end
                else
                begin
                    status_reg <= ST_INTERP;
                    if (f_zero)
                        f_reg <= '0;
                    else if (f_one)
                        f_reg <= F_W'(1) << FRAC_W;
                end
            end
            S_DIVIDE:
            begin
                if (div_done)
                    f_reg <= {1'b0, div_q};
            end
            S_LOAD:
            begin
                if (do_load)
                begin
                    out_x_reg      <= lane_res[0];
                    out_y_reg      <= lane_res[1];
                    out_z_reg      <= lane_res[2];
                    status_out_reg <= status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    kvts_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .an    (an),
        .ad    (ad),
        .done  (div_done),
        .quot  (div_q)
    );

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        kvts_lane u_lane (
            .clk (clk),
            .ctl (lane_ctl),
            .a   (a_reg[l*VAL_W +: VAL_W]),
            .b   (b_reg[l*VAL_W +: VAL_W]),
            .f   (f_reg),
            .res (lane_res[l])
        );
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign status    = status_out_reg;

endmodule

[rtl/kvts_checker.sv]
// Port-level checks of the keyframe track sampler and their binding.
`include "keyframe_vec3_track_sampler_macros.svh"

module kvts_checker
    import kvts_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              operation,
    input logic              out_valid,
    input logic              out_ready,
    input logic [VAL_W-1:0]  out_x,
    input logic [VAL_W-1:0]  out_y,
    input logic [VAL_W-1:0]  out_z,
    input logic [1:0]        status
);

    // A waiting result keeps its x component and its status until it is taken.
    `KVTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(status))

    // An empty track always answers with a zero vector.
    `KVTS_ASSERT_SAME(a_empty_zero, out_valid && status == ST_EMPTY, out_x == '0 && out_y == '0 && out_z == '0)

    // A sample item keeps the block busy for at least the next cycle.
    `KVTS_ASSERT_NEXT(a_sample_busy, in_valid && in_ready && operation == OP_SAMPLE, !in_ready)

    // A key write leaves the input side open.
    `KVTS_ASSERT_NEXT(a_write_open, in_valid && in_ready && operation == OP_WRITE, in_ready)

endmodule

bind keyframe_vec3_track_sampler kvts_checker u_kvts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .status    (status)
);
